### rtl/textrank_power_iteration_ranker_defines.svh
// ----------------------------------------------------------------------------
// TextRank ranker assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef TEXTRANK_POWER_ITERATION_RANKER_DEFINES_SVH
`define TEXTRANK_POWER_ITERATION_RANKER_DEFINES_SVH

// Check a consequence in the same cycle as its cause
`define TRPR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause
`define TRPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/trpr_pkg.sv
// ----------------------------------------------------------------------------
// TextRank ranker package
// Field widths, fixed-point constants, state type and control bundles.
// ----------------------------------------------------------------------------
package trpr_pkg;

    localparam int NODE_W     = 6;
    localparam int CNT_W      = 7;
    localparam int ITER_W     = 10;
    localparam int DAMP_W     = 16;
    localparam int THR_W      = 16;
    localparam int SIM_W      = 16;
    localparam int RSUM_W     = 22;
    localparam int SCORE_W    = 24;
    localparam int FRAC_W     = 16;
    localparam int P1_W       = SIM_W + SCORE_W;
    localparam int P2_W       = P1_W + DAMP_W + 1;
    localparam int DVD_W      = P2_W - 1;
    localparam int ACC_W      = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic signed [SCORE_W-1:0] SCORE_ONE = 24'sd65536;
    localparam logic signed [SCORE_W-1:0] SCORE_MAX = 24'sh7FFFFF;
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = 24'sh800000;

    localparam logic [CNT_W-1:0]  NODE_COUNT_RST = 7'd64;
    localparam logic [ITER_W-1:0] MAX_ITER_RST   = 10'd100;
    localparam logic [DAMP_W-1:0] DAMPING_RST    = 16'd55706;
    localparam logic [THR_W-1:0]  THRESHOLD_RST  = 16'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_COUNT,
        CFG_MAX_ITER,
        CFG_DAMPING,
        CFG_THRESHOLD
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RS_RD,
        S_RS_ACC,
        S_N_START,
        S_T_RD,
        S_T_MUL1,
        S_T_MUL2,
        S_T_DIVGO,
        S_T_DIV,
        S_T_ACC,
        S_N_RD,
        S_N_WR,
        S_ROUND,
        S_SORT_INIT,
        S_SCAN_START,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_EMIT,
        S_OUT_WAIT
    } t_state;

    typedef struct packed {
        logic              in_ready;
        logic              load;
        logic [NODE_W-1:0] row;
        logic [NODE_W-1:0] col;
        logic [NODE_W-1:0] sc_idx;
        logic              bank;
        logic              fresh;
        logic              rs_first;
        logic              rs_add;
        logic              rs_wr;
        logic              acc_init;
        logic              mul1;
        logic              mul2;
        logic              div_start;
        logic              acc_add;
        logic              node_wr;
        logic              round_begin;
        logic              settled_zero;
        logic              emit_clr;
        logic              best_clr;
        logic              scan_cmp;
        logic              out_load;
        logic              out_last;
    } t_cmd;

    typedef struct packed {
        logic rs_pos;
        logic div_done;
        logic settled;
        logic out_taken;
    } t_stat;

endpackage

### rtl/trpr_div.sv
// ----------------------------------------------------------------------------
// TextRank ranker divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module trpr_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [trpr_pkg::DVD_W-1:0]    i_dividend,
    input  logic [trpr_pkg::RSUM_W-1:0]   i_divisor,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [trpr_pkg::DVD_W-1:0]    o_quotient
);
    import trpr_pkg::*;

    localparam int CW = $clog2(DVD_W);

    logic [DVD_W-1:0]  r_dvd;
    logic [RSUM_W-1:0] r_rem;
    logic [RSUM_W-1:0] r_dvs;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [RSUM_W:0]   rem_sh;
    logic [RSUM_W:0]   rem_nx;
    logic              ge;

    // Trial subtract of the shifted remainder
    always_comb begin
        rem_sh = {r_rem, r_dvd[DVD_W-1]};
        ge     = (rem_sh >= {1'b0, r_dvs});
        rem_nx = ge ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
    end

    // Control: count quotient bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && (r_cnt == CW'(DVD_W - 1))) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    // Datapath: shift quotient bits in behind the dividend
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], ge};
            r_rem <= rem_nx[RSUM_W-1:0];
            r_cnt <= r_cnt + CW'(1);
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_dvd;

endmodule

### rtl/trpr_ctrl.sv
// ----------------------------------------------------------------------------
// TextRank ranker controller
// Sequences matrix load, row sums, power iteration rounds and ranked output.
// ----------------------------------------------------------------------------
module trpr_ctrl #(
    parameter int MAX_NODES = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_final_entry,
    input  logic [trpr_pkg::CNT_W-1:0]   i_node_count,
    input  logic [trpr_pkg::ITER_W-1:0]  i_max_iter,
    input  trpr_pkg::t_stat              i_stat,
    output trpr_pkg::t_cmd               o_cmd
);
    import trpr_pkg::*;

    localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

    t_state            r_state, n_state;
    logic [IW-1:0]     r_j, n_j;
    logic [IW-1:0]     r_k, n_k;
    logic [IW-1:0]     r_i, n_i;
    logic [IW-1:0]     r_pos, n_pos;
    logic [ITER_W-1:0] r_it, n_it;
    logic              r_bank, n_bank;
    logic              r_fresh, n_fresh;
    logic [CNT_W-1:0]  n_last;
    logic              j_last, k_last, i_last, pos_last, it_last;

    assign n_last   = i_node_count - CNT_W'(1);
    assign j_last   = (CNT_W'(r_j) == n_last);
    assign k_last   = (CNT_W'(r_k) == n_last);
    assign i_last   = (CNT_W'(r_i) == n_last);
    assign pos_last = (CNT_W'(r_pos) == n_last);
    assign it_last  = ((r_it + ITER_W'(1)) == i_max_iter);

    // State and loop counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_j     <= '0;
            r_k     <= '0;
            r_i     <= '0;
            r_pos   <= '0;
            r_it    <= '0;
            r_bank  <= 1'b0;
            r_fresh <= 1'b1;
        end else begin
            r_state <= n_state;
            r_j     <= n_j;
            r_k     <= n_k;
            r_i     <= n_i;
            r_pos   <= n_pos;
            r_it    <= n_it;
            r_bank  <= n_bank;
            r_fresh <= n_fresh;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_j     = r_j;
        n_k     = r_k;
        n_i     = r_i;
        n_pos   = r_pos;
        n_it    = r_it;
        n_bank  = r_bank;
        n_fresh = r_fresh;
        o_cmd        = '0;
        o_cmd.row    = NODE_W'(r_j);
        o_cmd.col    = NODE_W'(r_k);
        o_cmd.sc_idx = NODE_W'(r_j);
        o_cmd.bank   = r_bank;
        o_cmd.fresh  = r_fresh;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_final_entry) begin
                        n_j     = '0;
                        n_k     = '0;
                        n_state = S_RS_RD;
                    end
                end
            end
            S_RS_RD: begin
                n_state = S_RS_ACC;
            end
            S_RS_ACC: begin
                o_cmd.rs_add   = 1'b1;
                o_cmd.rs_first = (r_k == '0);
                n_state        = S_RS_RD;
                if (k_last) begin
                    o_cmd.rs_wr = 1'b1;
                    n_k         = '0;
                    if (j_last) begin
                        // start the rounds from scores of one
                        n_bank  = 1'b0;
                        n_fresh = 1'b1;
                        n_it    = '0;
                        n_i     = '0;
                        if (i_max_iter == '0) begin
                            o_cmd.settled_zero = 1'b1;
                            n_state            = S_SORT_INIT;
                        end else begin
                            o_cmd.round_begin = 1'b1;
                            n_state           = S_N_START;
                        end
                    end else begin
                        n_j = r_j + IW'(1);
                    end
                end else begin
                    n_k = r_k + IW'(1);
                end
            end
            S_N_START: begin
                o_cmd.acc_init = 1'b1;
                n_j            = '0;
                n_state        = S_T_RD;
            end
            S_T_RD: begin
                o_cmd.col = NODE_W'(r_i);
                n_state   = S_T_MUL1;
            end
            S_T_MUL1: begin
                o_cmd.mul1 = 1'b1;
                if ((r_j == r_i) || !i_stat.rs_pos) begin
                    if (j_last) begin
                        n_state = S_N_RD;
                    end else begin
                        n_j     = r_j + IW'(1);
                        n_state = S_T_RD;
                    end
                end else begin
                    n_state = S_T_MUL2;
                end
            end
            S_T_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_T_DIVGO;
            end
            S_T_DIVGO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_T_DIV;
            end
            S_T_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_T_ACC;
                end
            end
            S_T_ACC: begin
                o_cmd.acc_add = 1'b1;
                if (j_last) begin
                    n_state = S_N_RD;
                end else begin
                    n_j     = r_j + IW'(1);
                    n_state = S_T_RD;
                end
            end
            S_N_RD: begin
                o_cmd.sc_idx = NODE_W'(r_i);
                n_state      = S_N_WR;
            end
            S_N_WR: begin
                o_cmd.sc_idx  = NODE_W'(r_i);
                o_cmd.node_wr = 1'b1;
                if (i_last) begin
                    n_state = S_ROUND;
                end else begin
                    n_i     = r_i + IW'(1);
                    n_state = S_N_START;
                end
            end
            S_ROUND: begin
                // swap score banks and check the stop conditions
                n_bank  = ~r_bank;
                n_fresh = 1'b0;
                n_it    = r_it + ITER_W'(1);
                n_i     = '0;
                if (i_stat.settled || it_last) begin
                    n_state = S_SORT_INIT;
                end else begin
                    o_cmd.round_begin = 1'b1;
                    n_state           = S_N_START;
                end
            end
            S_SORT_INIT: begin
                o_cmd.emit_clr = 1'b1;
                n_pos          = '0;
                n_state        = S_SCAN_START;
            end
            S_SCAN_START: begin
                o_cmd.best_clr = 1'b1;
                n_j            = '0;
                n_state        = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                o_cmd.scan_cmp = 1'b1;
                if (j_last) begin
                    n_state = S_EMIT;
                end else begin
                    n_j     = r_j + IW'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_EMIT: begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_last = pos_last;
                n_state        = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                if (i_stat.out_taken) begin
                    if (pos_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_pos   = r_pos + IW'(1);
                        n_state = S_SCAN_START;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/trpr_dp.sv
// ----------------------------------------------------------------------------
// TextRank ranker datapath
// Matrix, row sum and score stores, multiply and divide chain, ranking scan
// and the result register.
// ----------------------------------------------------------------------------
`include "textrank_power_iteration_ranker_defines.svh"

module trpr_dp #(
    parameter int MAX_NODES = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  trpr_pkg::t_cmd                      i_cmd,
    output trpr_pkg::t_stat                     o_stat,
    input  logic [trpr_pkg::NODE_W-1:0]         i_row_index,
    input  logic [trpr_pkg::NODE_W-1:0]         i_col_index,
    input  logic signed [trpr_pkg::SIM_W-1:0]   i_sim_value,
    input  logic [trpr_pkg::DAMP_W-1:0]         i_damping,
    input  logic [trpr_pkg::THR_W-1:0]          i_threshold,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic [trpr_pkg::NODE_W-1:0]         o_node_index,
    output logic signed [trpr_pkg::SCORE_W-1:0] o_node_score,
    output logic                                o_converged_flag,
    output logic                                o_last_rank
);
    import trpr_pkg::*;

    localparam int IW        = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int SIM_DEPTH = 1 << (2 * IW);
    localparam int SC_DEPTH  = 2 << IW;
    localparam logic signed [ACC_W-1:0] ACC_SC_MAX = ACC_W'(SCORE_MAX);
    localparam logic signed [ACC_W-1:0] ACC_SC_MIN = ACC_W'(SCORE_MIN);

    logic signed [SIM_W-1:0]   sim_mem [SIM_DEPTH];
    logic signed [RSUM_W-1:0]  rs_mem  [MAX_NODES];
    logic signed [SCORE_W-1:0] sc_mem  [SC_DEPTH];

    logic signed [SIM_W-1:0]   r_sim_q;
    logic signed [RSUM_W-1:0]  r_rs_q;
    logic signed [SCORE_W-1:0] r_sc_q;
    logic signed [SCORE_W-1:0] sc_sel;
    logic                      in_range;

    logic signed [RSUM_W-1:0]  r_rsum;
    logic signed [RSUM_W-1:0]  rs_next;

    logic signed [P1_W-1:0]    r_p1;
    logic signed [P2_W-1:0]    r_p2;
    logic signed [P2_W-1:0]    p2_neg;
    logic [RSUM_W-1:0]         r_dvs;
    logic [DVD_W-1:0]          p2_mag;
    logic [DVD_W-1:0]          quo;
    logic                      div_busy;
    logic                      div_done;
    logic signed [ACC_W-1:0]   q_ext;
    logic signed [ACC_W-1:0]   term;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   acc_fl;
    logic [DAMP_W:0]           one_minus_d;

    logic signed [SCORE_W-1:0] new_sc;
    logic signed [SCORE_W:0]   diff;
    logic [SCORE_W:0]          absd;
    logic                      unsettled;
    logic                      r_settled;

    logic [MAX_NODES-1:0]      r_emitted;
    logic [IW-1:0]             r_best_idx;
    logic signed [SCORE_W-1:0] r_best_sc;
    logic                      r_best_vld;
    logic                      cand;

    logic                      r_out_valid;
    logic [NODE_W-1:0]         r_node_index;
    logic signed [SCORE_W-1:0] r_node_score;
    logic                      r_conv;
    logic                      r_last;

    // Matrix store: write on in-range load requests, read every cycle
    assign in_range = (CNT_W'(i_row_index) < CNT_W'(MAX_NODES)) &&
                      (CNT_W'(i_col_index) < CNT_W'(MAX_NODES));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && in_range) begin
            sim_mem[{i_row_index[IW-1:0], i_col_index[IW-1:0]}] <= i_sim_value;
        end
        r_sim_q <= sim_mem[{i_cmd.row[IW-1:0], i_cmd.col[IW-1:0]}];
    end

    // Row sum store
    assign rs_next = (i_cmd.rs_first ? RSUM_W'(0) : r_rsum) +
                     {{(RSUM_W-SIM_W){r_sim_q[SIM_W-1]}}, r_sim_q};

    always_ff @(posedge i_clk) begin
        if (i_cmd.rs_add) begin
            r_rsum <= rs_next;
        end
        if (i_cmd.rs_wr) begin
            rs_mem[i_cmd.row[IW-1:0]] <= rs_next;
        end
        r_rs_q <= rs_mem[i_cmd.row[IW-1:0]];
    end

    // Score store: two banks, read the current one, write the next one
    always_ff @(posedge i_clk) begin
        if (i_cmd.node_wr) begin
            sc_mem[{~i_cmd.bank, i_cmd.sc_idx[IW-1:0]}] <= new_sc;
        end
        r_sc_q <= sc_mem[{i_cmd.bank, i_cmd.sc_idx[IW-1:0]}];
    end

    // First round reads every score as one
    assign sc_sel = i_cmd.fresh ? SCORE_ONE : r_sc_q;

    // Multiply chain: sim * score, then * damping
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1) begin
            r_p1  <= r_sim_q * sc_sel;
            r_dvs <= r_rs_q[RSUM_W-1:0];
        end
        if (i_cmd.mul2) begin
            r_p2 <= r_p1 * $signed({1'b0, i_damping});
        end
    end

    // Divide magnitude by the row sum, truncate toward zero
    assign p2_neg = -r_p2;
    assign p2_mag = r_p2[P2_W-1] ? p2_neg[DVD_W-1:0] : r_p2[DVD_W-1:0];

    trpr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (p2_mag),
        .i_divisor  (r_dvs),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    assign q_ext       = {{(ACC_W-DVD_W){1'b0}}, quo};
    assign term        = r_p2[P2_W-1] ? -q_ext : q_ext;
    assign one_minus_d = 17'h10000 - {1'b0, i_damping};

    // Accumulate terms over the base of (1-d)
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_init) begin
            r_acc <= {{(ACC_W-DAMP_W-1-FRAC_W){1'b0}}, one_minus_d, {FRAC_W{1'b0}}};
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + term;
        end
    end

    // Floor, saturate and measure the change
    always_comb begin
        acc_fl = r_acc >>> FRAC_W;
        if (acc_fl > ACC_SC_MAX) begin
            new_sc = SCORE_MAX;
        end else if (acc_fl < ACC_SC_MIN) begin
            new_sc = SCORE_MIN;
        end else begin
            new_sc = acc_fl[SCORE_W-1:0];
        end
        diff      = {new_sc[SCORE_W-1], new_sc} - {sc_sel[SCORE_W-1], sc_sel};
        absd      = diff[SCORE_W] ? (-diff) : diff;
        unsettled = (absd > (SCORE_W+1)'(i_threshold));
    end

    // Track whether the round left every score within the threshold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settled <= 1'b0;
        end else if (i_cmd.round_begin) begin
            r_settled <= 1'b1;
        end else if (i_cmd.settled_zero) begin
            r_settled <= 1'b0;
        end else if (i_cmd.node_wr && unsettled) begin
            r_settled <= 1'b0;
        end
    end

    // Ranking scan: highest score not yet sent, ties to the lower index
    assign cand = !r_emitted[i_cmd.sc_idx[IW-1:0]] && (!r_best_vld || (sc_sel > r_best_sc));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emitted  <= '0;
            r_best_vld <= 1'b0;
        end else begin
            if (i_cmd.emit_clr) begin
                r_emitted <= '0;
            end else if (i_cmd.out_load) begin
                r_emitted[r_best_idx] <= 1'b1;
            end
            if (i_cmd.best_clr) begin
                r_best_vld <= 1'b0;
            end else if (i_cmd.scan_cmp && cand) begin
                r_best_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_cmp && cand) begin
            r_best_idx <= i_cmd.sc_idx[IW-1:0];
            r_best_sc  <= sc_sel;
        end
    end

    // Result register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_node_index <= NODE_W'(r_best_idx);
            r_node_score <= r_best_sc;
            r_conv       <= r_settled;
            r_last       <= i_cmd.out_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_node_index     = r_node_index;
    assign o_node_score     = r_node_score;
    assign o_converged_flag = r_conv;
    assign o_last_rank      = r_last;

    assign o_stat.rs_pos    = (r_rs_q > RSUM_W'(0));
    assign o_stat.div_done  = div_done;
    assign o_stat.settled   = r_settled;
    assign o_stat.out_taken = r_out_valid && !i_out_stall;

    `TRPR_ASSERT_NOW(a_load_when_empty, i_cmd.out_load, !r_out_valid, "result loaded over a pending one")
    `TRPR_ASSERT_NOW(a_emit_once, i_cmd.out_load, r_best_vld && !r_emitted[r_best_idx], "node ranked twice")
    `TRPR_ASSERT_NOW(a_acc_after_div, i_cmd.acc_add, div_done && !div_busy, "term added before quotient ready")
    `TRPR_ASSERT_NEXT(a_div_runs, i_cmd.div_start, div_busy && !div_done, "divider did not start")

endmodule

### rtl/textrank_power_iteration_ranker.sv
// A request without the final mark is taken in the cycle it is offered; the final request
// starts the row sums, then the rounds, in which each off-diagonal term with a positive row
// sum goes through the divider and every other term, diagonal included, skips it, and then
// the ranking.
// Throughput: one ranking run at a time; no request is taken until the last result is taken.
// Reset: i_rst_n is synchronous, active low; registers take their defaults, the matrix is kept.
// ----------------------------------------------------------------------------
// TextRank power iteration ranker
// Loads a similarity matrix, runs damped power iteration and emits nodes best first.
// ----------------------------------------------------------------------------
module textrank_power_iteration_ranker #(
    parameter int MAX_NODES = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [trpr_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [trpr_pkg::CFG_DATA_W-1:0]         i_cfg_wdata,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic [trpr_pkg::NODE_W-1:0]             i_row_index,
    input  logic [trpr_pkg::NODE_W-1:0]             i_col_index,
    input  logic signed [trpr_pkg::SIM_W-1:0]       i_sim_value,
    input  logic                                    i_final_entry,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic [trpr_pkg::NODE_W-1:0]             o_node_index,
    output logic signed [trpr_pkg::SCORE_W-1:0]     o_node_score,
    output logic                                    o_converged_flag,
    output logic                                    o_last_rank
);
    import trpr_pkg::*;

    logic [CNT_W-1:0]  r_node_count;
    logic [ITER_W-1:0] r_max_iter;
    logic [DAMP_W-1:0] r_damping;
    logic [THR_W-1:0]  r_threshold;
    logic [CNT_W-1:0]  node_count_eff;
    t_cmd              cmd;
    t_stat             stat;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RST;
            r_max_iter   <= MAX_ITER_RST;
            r_damping    <= DAMPING_RST;
            r_threshold  <= THRESHOLD_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_NODE_COUNT: r_node_count <= i_cfg_wdata[CNT_W-1:0];
                CFG_MAX_ITER:   r_max_iter   <= i_cfg_wdata[ITER_W-1:0];
                CFG_DAMPING:    r_damping    <= i_cfg_wdata[DAMP_W-1:0];
                CFG_THRESHOLD:  r_threshold  <= i_cfg_wdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp node count into one..MAX_NODES
    always_comb begin
        if (r_node_count == '0) begin
            node_count_eff = CNT_W'(1);
        end else if (r_node_count > CNT_W'(MAX_NODES)) begin
            node_count_eff = CNT_W'(MAX_NODES);
        end else begin
            node_count_eff = r_node_count;
        end
    end

    trpr_ctrl #(
        .MAX_NODES (MAX_NODES)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_final_entry (i_final_entry),
        .i_node_count  (node_count_eff),
        .i_max_iter    (r_max_iter),
        .i_stat        (stat),
        .o_cmd         (cmd)
    );

    trpr_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_row_index      (i_row_index),
        .i_col_index      (i_col_index),
        .i_sim_value      (i_sim_value),
        .i_damping        (r_damping),
        .i_threshold      (r_threshold),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_node_index     (o_node_index),
        .o_node_score     (o_node_score),
        .o_converged_flag (o_converged_flag),
        .o_last_rank      (o_last_rank)
    );

    assign o_in_stall = ~cmd.in_ready;

endmodule
